// ===== design/nth_common_multiple_finder_unit_macros.svh =====
// Assertion macros for the nth common multiple finder.
// Included by the top level; expects signals named clock and reset in scope.
`ifndef NTH_COMMON_MULTIPLE_FINDER_UNIT_MACROS_SVH
`define NTH_COMMON_MULTIPLE_FINDER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define NCMF_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nth_cmf: same-cycle check failed");
`define NCMF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nth_cmf: next-cycle check failed");
`else
`define NCMF_ASSERT_IMPL(label, ante, cons)
`define NCMF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/nth_cmf_pkg.sv =====
// Shared types and constants for the nth common multiple finder.
// No dependencies; imported by the top level.
package nth_cmf_pkg;

   localparam int DEF_COUNT_BITS   = 32;
   localparam int DEF_DIVISOR_BITS = 16;
   localparam int ANSWER_BITS      = 30;

   localparam logic [ANSWER_BITS-1:0] ANSWER_MODULUS = 30'd1000000007;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PROD,
      S_GCD_TEST,
      S_GCD_WAIT,
      S_LCM_WAIT,
      S_LCM_MUL,
      S_HI_MUL,
      S_MID,
      S_LAUNCH_A,
      S_QA_WAIT,
      S_QB_WAIT,
      S_QL_WAIT,
      S_DECIDE,
      S_MOD_LAUNCH,
      S_MOD_WAIT,
      S_OUT
   } state_type;

endpackage

// ===== design/nth_cmf_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Standalone; shared by every division and remainder in the finder.
module nth_cmf_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot,
   output logic [DEN_W-1:0] rem
);

   localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DEN_W:0] shifted;
   logic [DEN_W:0] diff;
   logic           fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder always stays below a nonzero divisor.
         rem_in  = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule

// ===== design/nth_common_multiple_finder_unit.sv =====
// Channel | Direction | Beat contents
// req     | in        | target_count, divisor_a, divisor_b
// rsp     | out       | answer_mod
//
// Each item runs its divisions one at a time on the shared radix-2 divider, which produces
// VAL_W quotient bits (48 at default widths) per division. Each Euclid step is one division,
// the search takes about log2(min(a,b)*n) rounds (up to 48) of three divisions, and the
// final reduction is one more division. Reset is synchronous and clears the sequencer,
// rsp_valid and the divider's busy and done flags only.
// A finished result moves to an output register, so the next beat is accepted while it
// waits on rsp; the sequencer stalls only when its next result is ready before that.
// Depends on nth_cmf_pkg, nth_cmf_div and the assertion macro header.
`include "nth_common_multiple_finder_unit_macros.svh"

module nth_common_multiple_finder_unit #(
   parameter int COUNT_BITS   = nth_cmf_pkg::DEF_COUNT_BITS,
   parameter int DIVISOR_BITS = nth_cmf_pkg::DEF_DIVISOR_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [COUNT_BITS-1:0]              req_target_count,
   input  logic [DIVISOR_BITS-1:0]            req_divisor_a,
   input  logic [DIVISOR_BITS-1:0]            req_divisor_b,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [nth_cmf_pkg::ANSWER_BITS-1:0] rsp_answer_mod
);
   import nth_cmf_pkg::*;

   localparam int DB    = DIVISOR_BITS;
   localparam int MUL_W = (COUNT_BITS > DB) ? COUNT_BITS : DB;
   localparam int VAL_W = DB + MUL_W;
   localparam int CNT_W = VAL_W + 1;
   localparam int DEN_W = (2 * DB > ANSWER_BITS) ? 2 * DB : ANSWER_BITS;

   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0]  n_ff, n_in;
   logic [DB-1:0]          a_ff, a_in;
   logic [DB-1:0]          b_ff, b_in;
   logic [DB-1:0]          x_ff, x_in;
   logic [DB-1:0]          y_ff, y_in;
   logic [DB-1:0]          q_ff, q_in;
   logic [2*DB-1:0]        lcm_ff, lcm_in;
   logic [VAL_W-1:0]       lo_ff, lo_in;
   logic [VAL_W-1:0]       hi_ff, hi_in;
   logic [VAL_W-1:0]       mid_ff, mid_in;
   logic [VAL_W-1:0]       value_ff, value_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [ANSWER_BITS-1:0] ans_ff, ans_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [ANSWER_BITS-1:0] rsp_answer_ff, rsp_answer_in;

   logic [DB-1:0]    mul_x;
   logic [MUL_W-1:0] mul_y;
   logic [VAL_W-1:0] product;

   logic             div_start;
   logic [VAL_W-1:0] div_num;
   logic [DEN_W-1:0] div_den;
   logic             div_done;
   logic [VAL_W-1:0] div_quot;
   logic [DEN_W-1:0] div_rem;

   nth_cmf_div #(
      .NUM_W(VAL_W),
      .DEN_W(DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   // The one multiplier is shared by the lcm, the search bound and the one-divisor case.
   assign product = VAL_W'(mul_x) * VAL_W'(mul_y);

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      q_in          = q_ff;
      lcm_in        = lcm_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      value_in      = value_ff;
      cnt_in        = cnt_ff;
      ans_in        = ans_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_answer_in = rsp_answer_ff;
      mul_x         = '0;
      mul_y         = '0;
      div_start     = 1'b0;
      div_num       = '0;
      div_den       = '0;
      req_ready     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               n_in = req_target_count;
               a_in = req_divisor_a;
               b_in = req_divisor_b;
               x_in = req_divisor_a;
               y_in = req_divisor_b;
               // No qualifying number exists for a zero count or two zero divisors.
               if (req_target_count == '0 ||
                   (req_divisor_a == '0 && req_divisor_b == '0)) begin
                  ans_in   = '0;
                  state_in = S_OUT;
               end else if (req_divisor_a == '0 || req_divisor_b == '0) begin
                  state_in = S_PROD;
               end else begin
                  state_in = S_GCD_TEST;
               end
            end
         end
         S_PROD: begin
            mul_x    = (a_ff == '0) ? b_ff : a_ff;
            mul_y    = MUL_W'(n_ff);
            value_in = product;
            state_in = S_MOD_LAUNCH;
         end
         S_GCD_TEST: begin
            div_start = 1'b1;
            if (y_ff == '0) begin
               div_num  = VAL_W'(a_ff);
               div_den  = DEN_W'(x_ff);
               state_in = S_LCM_WAIT;
            end else begin
               div_num  = VAL_W'(x_ff);
               div_den  = DEN_W'(y_ff);
               state_in = S_GCD_WAIT;
            end
         end
         S_GCD_WAIT: begin
            if (div_done) begin
               x_in     = y_ff;
               y_in     = div_rem[DB-1:0];
               state_in = S_GCD_TEST;
            end
         end
         S_LCM_WAIT: begin
            if (div_done) begin
               q_in     = div_quot[DB-1:0];
               state_in = S_LCM_MUL;
            end
         end
         S_LCM_MUL: begin
            mul_x    = q_ff;
            mul_y    = MUL_W'(b_ff);
            lcm_in   = product[2*DB-1:0];
            state_in = S_HI_MUL;
         end
         S_HI_MUL: begin
            mul_x    = (a_ff < b_ff) ? a_ff : b_ff;
            mul_y    = MUL_W'(n_ff);
            hi_in    = product;
            lo_in    = VAL_W'(1);
            state_in = S_MID;
         end
         S_MID: begin
            if (lo_ff < hi_ff) begin
               mid_in   = lo_ff + ((hi_ff - lo_ff) >> 1);
               state_in = S_LAUNCH_A;
            end else begin
               value_in = lo_ff;
               state_in = S_MOD_LAUNCH;
            end
         end
         S_LAUNCH_A: begin
            div_start = 1'b1;
            div_num   = mid_ff;
            div_den   = DEN_W'(a_ff);
            state_in  = S_QA_WAIT;
         end
         S_QA_WAIT: begin
            if (div_done) begin
               cnt_in    = CNT_W'(div_quot);
               div_start = 1'b1;
               div_num   = mid_ff;
               div_den   = DEN_W'(b_ff);
               state_in  = S_QB_WAIT;
            end
         end
         S_QB_WAIT: begin
            if (div_done) begin
               cnt_in    = cnt_ff + CNT_W'(div_quot);
               div_start = 1'b1;
               div_num   = mid_ff;
               div_den   = DEN_W'(lcm_ff);
               state_in  = S_QL_WAIT;
            end
         end
         S_QL_WAIT: begin
            if (div_done) begin
               // Multiples of the lcm were counted twice.
               cnt_in   = cnt_ff - CNT_W'(div_quot);
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (cnt_ff >= CNT_W'(n_ff)) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + VAL_W'(1);
            end
            state_in = S_MID;
         end
         S_MOD_LAUNCH: begin
            div_start = 1'b1;
            div_num   = value_ff;
            div_den   = DEN_W'(ANSWER_MODULUS);
            state_in  = S_MOD_WAIT;
         end
         S_MOD_WAIT: begin
            if (div_done) begin
               ans_in   = div_rem[ANSWER_BITS-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // The result moves out once the output register is empty or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = ans_ff;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      q_ff          <= q_in;
      lcm_ff        <= lcm_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      value_ff      <= value_in;
      cnt_ff        <= cnt_in;
      ans_ff        <= ans_in;
      rsp_answer_ff <= rsp_answer_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_answer_mod = rsp_answer_ff;

   `NCMF_ASSERT_IMPL(a_search_ordered, state_ff == S_MID, lo_ff <= hi_ff)
   `NCMF_ASSERT_IMPL(a_mid_inside, state_ff == S_DECIDE, (lo_ff <= mid_ff) && (mid_ff < hi_ff))
   `NCMF_ASSERT_IMPL(a_answer_reduced, rsp_valid, rsp_answer_mod < ANSWER_MODULUS)
   `NCMF_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

endmodule
